// ===== hw/rtl/lagged_letter_coincidence_counter_assert.svh =====
// Assertion macros for the lagged letter coincidence counter checker.
`ifndef LAGGED_LETTER_COINCIDENCE_COUNTER_ASSERT_SVH
`define LAGGED_LETTER_COINCIDENCE_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LLCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define LLCC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/llcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_pkg
// Shared widths, constants and the cell control bundle for the lagged
// letter coincidence counter.
// ----------------------------------------------------------------------------
package llcc_pkg;

    localparam int BYTE_W          = 8;
    localparam int LAG_W           = 5;
    localparam int OUT_CNT_W       = 16;
    localparam int MAX_LAG_DEF     = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [BYTE_W-1:0] LOWER_A       = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z       = 8'h7A;
    localparam logic [LAG_W-1:0]  MAX_LAG_RESET = 5'd16;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic advance;  // an input item is accepted
        logic clear;    // that item ends the text
        logic load;     // capture report values
        logic shift;    // report chain moves one place toward the output
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/llcc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_cell
// One lag of the counter: a delay line byte, a saturating coincidence
// counter and one stage of the report shift chain.
// ----------------------------------------------------------------------------
module llcc_cell #(
    parameter int COUNT_WIDTH = llcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  llcc_pkg::cell_ctrl_t              ctrl,
    input  logic [llcc_pkg::BYTE_W-1:0]       new_byte,
    input  logic                              new_is_letter,
    input  logic [llcc_pkg::BYTE_W-1:0]       byte_in,
    output logic [llcc_pkg::BYTE_W-1:0]       byte_out,
    input  logic [llcc_pkg::OUT_CNT_W-1:0]    rep_in,
    output logic [llcc_pkg::OUT_CNT_W-1:0]    rep_out
);

    localparam int EXT_W = (COUNT_WIDTH > llcc_pkg::OUT_CNT_W) ?
                           COUNT_WIDTH : llcc_pkg::OUT_CNT_W;

    logic [llcc_pkg::BYTE_W-1:0]    byte_reg;
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic [llcc_pkg::OUT_CNT_W-1:0] rep_reg;
    logic [EXT_W-1:0]               count_ext;
    logic                           hit;

    assign hit        = new_is_letter && (byte_reg == new_byte) && !(&count_reg);
    assign count_next = hit ? count_reg + COUNT_WIDTH'(1) : count_reg;
    assign count_ext  = EXT_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg  <= '0;
            count_reg <= '0;
        end else if (ctrl.advance) begin
            if (ctrl.clear) begin
                byte_reg  <= '0;
                count_reg <= '0;
            end else begin
                byte_reg  <= byte_in;
                count_reg <= count_next;
            end
        end
    end

    // Report stage: load includes the count of the ending byte itself.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            rep_reg <= count_ext[llcc_pkg::OUT_CNT_W-1:0];
        end else if (ctrl.shift) begin
            rep_reg <= rep_in;
        end
    end

    assign byte_out = byte_reg;
    assign rep_out  = rep_reg;

endmodule

// ===== hw/rtl/lagged_letter_coincidence_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_letter_coincidence_counter
// Counts equal lowercase letter pairs at every lag of a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per item, s_text_end set on the final byte.
//   m_ channel: on each text end, one result per lag 1..max_lag in ascending
//   order, m_final_lag set on the last one.
//   cfg_we/cfg_wdata write max_lag (0 acts as 1, above MAX_LAG saturates).
// Throughput: one byte per cycle. A row of MAX_LAG cells each compares its
//   delay byte with the incoming byte and bumps its own counter in parallel.
// Latency: the first result is valid the cycle after the ending byte is
//   accepted; a report of N lags drains at one result per cycle while m_ready is high.
// Reports are captured into a shift chain, so the next text streams in while
//   a report drains. An ending byte waits (s_ready low) until the final
//   result of the previous report is taken; it can go in that same cycle.
// A stalled receiver holds the current result; text bytes keep flowing.
// Reset clears the delay line, counters and any pending report and sets
//   max_lag to 16.
// ----------------------------------------------------------------------------
module lagged_letter_coincidence_counter #(
    parameter int MAX_LAG     = llcc_pkg::MAX_LAG_DEF,
    parameter int COUNT_WIDTH = llcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [llcc_pkg::LAG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [llcc_pkg::BYTE_W-1:0]       s_text_byte,
    input  logic                              s_text_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [llcc_pkg::LAG_W-1:0]        m_lag,
    output logic [llcc_pkg::OUT_CNT_W-1:0]    m_coincidences,
    output logic                              m_final_lag
);

    localparam int IDX_W = $clog2(MAX_LAG + 1);
    localparam int LIM_W = (IDX_W > llcc_pkg::LAG_W) ? IDX_W : llcc_pkg::LAG_W;

    logic [llcc_pkg::LAG_W-1:0]     max_lag_reg;
    logic [IDX_W-1:0]               remain_reg;
    logic [LIM_W-1:0]               lag_reg;
    logic [LIM_W-1:0]               limit;
    logic [LIM_W-1:0]               max_lag_ext;
    logic                           is_letter;
    logic                           rep_free;
    logic                           pop;
    llcc_pkg::cell_ctrl_t           ctrl;

    logic [llcc_pkg::BYTE_W-1:0]    byte_chain [MAX_LAG+1];
    logic [llcc_pkg::OUT_CNT_W-1:0] rep_chain  [MAX_LAG+1];

    assign is_letter = (s_text_byte >= llcc_pkg::LOWER_A) &&
                       (s_text_byte <= llcc_pkg::LOWER_Z);

    // Report chain is free for a new capture once its last result leaves.
    assign pop      = m_valid && m_ready;
    assign rep_free = (remain_reg == '0) || ((remain_reg == IDX_W'(1)) && m_ready);
    assign s_ready  = aresetn && (!s_text_end || rep_free);

    assign ctrl.advance = s_valid && s_ready;
    assign ctrl.clear   = s_text_end;
    assign ctrl.load    = s_valid && s_ready && s_text_end;
    assign ctrl.shift   = pop;

    // Clamp the register to 1..MAX_LAG.
    assign max_lag_ext = LIM_W'(max_lag_reg);
    always_comb begin
        if (max_lag_ext == '0) begin
            limit = LIM_W'(1);
        end else if (max_lag_ext > LIM_W'(MAX_LAG)) begin
            limit = LIM_W'(MAX_LAG);
        end else begin
            limit = max_lag_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lag_reg <= llcc_pkg::MAX_LAG_RESET;
        end else if (cfg_we) begin
            max_lag_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
            lag_reg    <= '0;
        end else if (ctrl.load) begin
            remain_reg <= IDX_W'(limit);
            lag_reg    <= LIM_W'(1);
        end else if (pop) begin
            remain_reg <= remain_reg - IDX_W'(1);
            lag_reg    <= lag_reg + LIM_W'(1);
        end
    end

    assign byte_chain[0]       = s_text_byte;
    assign rep_chain[MAX_LAG]  = '0;

    for (genvar t = 0; t < MAX_LAG; t++) begin : g_cell
        llcc_cell #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .new_byte      (s_text_byte),
            .new_is_letter (is_letter),
            .byte_in       (byte_chain[t]),
            .byte_out      (byte_chain[t+1]),
            .rep_in        (rep_chain[t+1]),
            .rep_out       (rep_chain[t])
        );
    end

    assign m_valid        = (remain_reg != '0);
    assign m_lag          = lag_reg[llcc_pkg::LAG_W-1:0];
    assign m_coincidences = rep_chain[0];
    assign m_final_lag    = (remain_reg == IDX_W'(1));

endmodule

// ===== hw/rtl/llcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcc_checker
// Port-level checks on report ordering and result hold for the counter.
// ----------------------------------------------------------------------------
`include "lagged_letter_coincidence_counter_assert.svh"

module llcc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_text_end,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [llcc_pkg::LAG_W-1:0]        m_lag,
    input logic [llcc_pkg::OUT_CNT_W-1:0]    m_coincidences,
    input logic                              m_final_lag
);

    // Within a report the lags climb by one.
    `LLCC_ASSERT_NXT(a_lag_ascends, m_valid && m_ready && !m_final_lag, m_valid && (m_lag == llcc_pkg::LAG_W'($past(m_lag) + 1'b1)), "report lag did not advance by one")

    // A new report always opens at lag one.
    `LLCC_ASSERT_NXT(a_report_starts, m_valid && m_ready && m_final_lag, !m_valid || (m_lag == llcc_pkg::LAG_W'(1)), "report did not start at lag one")

    // An accepted ending byte yields a report next cycle.
    `LLCC_ASSERT_NXT(a_end_reports, s_valid && s_ready && s_text_end, m_valid, "text end gave no report")

    // A stalled result holds.
    `LLCC_ASSERT_NXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_lag) && $stable(m_coincidences) && $stable(m_final_lag), "stalled result changed")

endmodule

bind lagged_letter_coincidence_counter llcc_checker u_llcc_checker (.*);

// ===== tb/lagged_letter_coincidence_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_letter_coincidence_counter_tb
// Streams texts through the coincidence counter and checks every per-lag
// report against a software copy of the delay line and lag counters. Both
// stream sides idle at random, one test starves the output so the block
// fills up, and max_lag is swept across its legal and out-of-range values.
// ----------------------------------------------------------------------------
module lagged_letter_coincidence_counter_tb;

    localparam int BYTE_W    = llcc_pkg::BYTE_W;
    localparam int LAG_W     = llcc_pkg::LAG_W;
    localparam int OUT_CNT_W = llcc_pkg::OUT_CNT_W;
    localparam logic [BYTE_W-1:0] LOWER_A       = llcc_pkg::LOWER_A;
    localparam logic [BYTE_W-1:0] LOWER_Z       = llcc_pkg::LOWER_Z;
    localparam logic [LAG_W-1:0]  MAX_LAG_RESET = llcc_pkg::MAX_LAG_RESET;

    localparam int LAGS            = llcc_pkg::MAX_LAG_DEF;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_ITEMS    = 100;
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [LAG_W-1:0]     lag;
        logic [OUT_CNT_W-1:0] coincidences;
        logic                 final_lag;
    } lag_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [LAG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_text_byte;
    logic                 s_text_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [LAG_W-1:0]     m_lag;
    logic [OUT_CNT_W-1:0] m_coincidences;
    logic                 m_final_lag;

    // software copy of the block state
    logic [BYTE_W-1:0]    shadow_bytes [LAGS];
    logic [OUT_CNT_W-1:0] shadow_counts [LAGS];
    logic [LAG_W-1:0]     shadow_max_lag;
    lag_report_t          report_queue [$];

    int          mismatches     = 0;
    int          stall_cycles   = 0;
    bit          tx_idle_on     = 1'b1;
    bit          rx_idle_on     = 1'b1;
    int unsigned rx_hold_cycles = 0;

    lagged_letter_coincidence_counter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_text_end     (s_text_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lag          (m_lag),
        .m_coincidences (m_coincidences),
        .m_final_lag    (m_final_lag)
    );

    always #1 aclk = ~aclk;

    function automatic void clear_shadow_text();
        int t;
        for (t = 0; t < LAGS; t++) begin
            shadow_bytes[t]  = '0;
            shadow_counts[t] = '0;
        end
    endfunction

    // Bump every lag whose delayed byte matches, shift the byte in, and on
    // the text end queue one report per lag up to the clamped max_lag.
    function automatic void count_text_byte(input logic [BYTE_W-1:0] text_byte,
                                            input logic text_end);
        int          t;
        int          limit;
        lag_report_t rep;
        if (text_byte >= LOWER_A && text_byte <= LOWER_Z) begin
            for (t = 0; t < LAGS; t++) begin
                if (shadow_bytes[t] == text_byte && shadow_counts[t] != COUNT_MAX)
                    shadow_counts[t]++;
            end
        end
        for (t = LAGS - 1; t > 0; t--)
            shadow_bytes[t] = shadow_bytes[t - 1];
        shadow_bytes[0] = text_byte;
        if (text_end) begin
            limit = int'(shadow_max_lag);
            if (limit == 0)
                limit = 1;
            if (limit > LAGS)
                limit = LAGS;
            for (t = 0; t < limit; t++) begin
                rep.lag          = LAG_W'(t + 1);
                rep.coincidences = shadow_counts[t];
                rep.final_lag    = (t + 1 == limit);
                report_queue.push_back(rep);
            end
            clear_shadow_text();
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_text_byte(input int unsigned span);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return LOWER_A + BYTE_W'($urandom_range(0, span - 1));
        if (roll < 9)
            return BYTE_W'($urandom_range(0, 255));
        // just outside the letter range
        return ($urandom_range(0, 1) != 0) ? LOWER_A - 8'd1 : LOWER_Z + 8'd1;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            count_text_byte(s_text_byte, s_text_end);
    end

    always @(posedge aclk) begin
        lag_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_queue.size() == 0) begin
                $display("%0t: unexpected result lag=%0d coincidences=%0d final_lag=%0b",
                         $time, m_lag, m_coincidences, m_final_lag);
                mismatches++;
            end else begin
                want = report_queue.pop_front();
                if (m_lag !== want.lag) begin
                    $display("%0t: lag expected %0d actual %0d", $time, want.lag, m_lag);
                    mismatches++;
                end
                if (m_coincidences !== want.coincidences) begin
                    $display("%0t: coincidences at lag %0d expected %0d actual %0d",
                             $time, want.lag, want.coincidences, m_coincidences);
                    mismatches++;
                end
                if (m_final_lag !== want.final_lag) begin
                    $display("%0t: final_lag at lag %0d expected %0b actual %0b",
                             $time, want.lag, want.final_lag, m_final_lag);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("lagged_letter_coincidence_counter_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side: random gap before each item, plus a long hold-off on request.
    initial begin
        int unsigned gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready) && rx_hold_cycles == 0);
        end
    end

    task automatic send_char(input logic [BYTE_W-1:0] text_byte, input logic text_end);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= text_byte;
        s_text_end  <= text_end;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_string(input string txt, input bit closes);
        int k;
        for (k = 0; k < txt.len(); k++)
            send_char(txt[k], closes && k == txt.len() - 1);
    endtask

    // Drop valid and wait until every queued report has come out.
    task automatic drain_reports();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (report_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_lag(input logic [LAG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        shadow_max_lag = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // One-byte text at the reset max_lag: every lag reaches before the start.
    task automatic test_default_short_text();
        send_char(LOWER_A, 1'b1);
        drain_reports();
    endtask

    task automatic test_letter_range();
        send_char(LOWER_A, 1'b0);
        send_char(LOWER_Z, 1'b0);
        send_char(LOWER_A - 8'd1, 1'b0);
        send_char(LOWER_Z + 8'd1, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(LOWER_A, 1'b0);
        send_char(LOWER_Z, 1'b1);
        drain_reports();
    endtask

    task automatic test_lag_register();
        write_max_lag(5'd0);
        send_string("aa", 1'b1);
        drain_reports();
        write_max_lag(5'd31);
        send_string("bcb", 1'b1);
        drain_reports();
        write_max_lag(5'd17);
        send_string("a", 1'b1);
        drain_reports();
        write_max_lag(5'd1);
        send_string("cc", 1'b1);
        drain_reports();
    endtask

    // Counts for all lags keep running; max_lag only trims the report.
    task automatic test_lag_change_mid_text();
        write_max_lag(5'd2);
        send_string("abab", 1'b0);
        drain_reports();
        write_max_lag(5'd16);
        send_string("a", 1'b1);
        drain_reports();
    endtask

    // Starve the output so a second text end has to wait on the first report.
    task automatic test_output_backpressure();
        int unsigned k;
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (3) begin
            for (k = 0; k < 10; k++)
                send_char(pick_text_byte(4), k == 9);
        end
        drain_reports();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_texts();
        int unsigned sent;
        int unsigned len;
        int unsigned span;
        int unsigned k;
        bit          closes;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                drain_reports();
                write_max_lag(LAG_W'($urandom_range(0, 31)));
            end
            len    = $urandom_range(1, 24);
            span   = $urandom_range(1, 26);
            closes = ($urandom_range(0, 7) != 0);
            for (k = 0; k < len; k++)
                send_char(pick_text_byte(span), closes && k == len - 1);
            sent += len;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        drain_reports();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_text_byte <= '0;
        s_text_end  <= 1'b0;
        clear_shadow_text();
        shadow_max_lag = MAX_LAG_RESET;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_short_text();
        test_letter_range();
        test_lag_register();
        test_lag_change_mid_text();
        test_output_backpressure();
        test_random_texts();

        if (mismatches == 0 && report_queue.size() == 0)
            $display("lagged_letter_coincidence_counter_tb: PASS");
        else
            $display("lagged_letter_coincidence_counter_tb: FAIL");
        $finish;
    end

endmodule
